### src/fbm_pkg.sv
package fbm_pkg;

    localparam int MAX_OCTAVES = 8;

    // hash multipliers, only their low 16 bits reach the fraction
    localparam logic [15:0] K_HX_LO   = 16'd58786;
    localparam logic [15:0] K_HY_LO   = 16'd27722;
    localparam logic [15:0] K_HZ_LO   = 16'd12780;
    localparam logic [20:0] K_BIAS    = 21'd1257636;
    localparam logic [17:0] K_SCALE   = 18'd135660;
    localparam logic [31:0] K_OFFX    = 32'd8585;
    localparam logic [31:0] K_OFFY    = 32'd14221;
    localparam logic [31:0] K_OFFZ    = 32'd22544;
    localparam logic [15:0] K_DECAY   = 16'd31457;
    localparam logic [15:0] AMP_START = 16'd32768;
    localparam logic [25:0] FIFTEEN_ONE = 26'd983040;
    localparam logic [19:0] TEN_ONE   = 20'd655360;
    localparam logic [25:0] HALF      = 26'd32768;

    localparam logic [4:0] LAST_FADE   = 5'd11;
    localparam logic [4:0] LAST_AXHASH = 5'd5;
    localparam logic [4:0] LAST_CORNER = 5'd31;
    localparam logic [4:0] LAST_LERP   = 5'd6;
    localparam logic [4:0] LAST_ACC    = 5'd1;
    localparam logic [4:0] LAST_ADV    = 5'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FADE,
        ST_AXHASH,
        ST_CORNER,
        ST_LERP,
        ST_ACC,
        ST_ADV,
        ST_DONE
    } fbm_state_t;

    typedef struct packed {
        logic idle;
        logic done;
    } fbm_status_t;

    typedef struct packed {
        logic [2:0] la;
        logic [2:0] lb;
        logic [1:0] ax;
    } fbm_lerp_t;

    // trilinear reduction done in place over the corner registers
    function automatic fbm_lerp_t lerp_sel(input logic [2:0] k);
        fbm_lerp_t s;
        case (k)
            3'd0:    s = '{la: 3'd0, lb: 3'd1, ax: 2'd0};
            3'd1:    s = '{la: 3'd2, lb: 3'd3, ax: 2'd0};
            3'd2:    s = '{la: 3'd4, lb: 3'd5, ax: 2'd0};
            3'd3:    s = '{la: 3'd6, lb: 3'd7, ax: 2'd0};
            3'd4:    s = '{la: 3'd0, lb: 3'd2, ax: 2'd1};
            3'd5:    s = '{la: 3'd4, lb: 3'd6, ax: 2'd1};
            default: s = '{la: 3'd0, lb: 3'd4, ax: 2'd2};
        endcase
        return s;
    endfunction

endpackage

### src/fbm_mul.sv
module fbm_mul
(
    input  logic signed [32:0] a,
    input  logic signed [25:0] b,
    output logic signed [58:0] p
);

    assign p = a * b;

endmodule

### src/fbm_core.sv
module fbm_core
    import fbm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [23:0] x_coord,
    input  logic [23:0] y_coord,
    input  logic [23:0] z_coord,
    input  logic [3:0]  octave_count,
    input  logic        result_taken,
    output fbm_status_t status,
    output logic [7:0]  noise_value
);

    fbm_state_t state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [3:0]  oct_reg, oct_next;
    logic [15:0] amp_reg, amp_next;
    logic [16:0] acc_reg, acc_next;
    logic [15:0] f3_reg, f3_next;
    logic [19:0] t_reg, t_next;
    logic [22:0] d_reg, d_next;
    logic [31:0] crd_reg [3];
    logic [31:0] crd_next [3];
    logic [16:0] fade_reg [3];
    logic [16:0] fade_next [3];
    logic [15:0] ah_reg [6];
    logic [15:0] ah_next [6];
    logic [15:0] crn_reg [8];
    logic [15:0] crn_next [8];

    logic signed [32:0] mul_a;
    logic signed [25:0] mul_b;
    logic signed [58:0] prod;

    logic [1:0]  fax;
    logic [15:0] frac;
    logic [20:0] six_f;
    logic [1:0]  hax;
    logic [15:0] lat_cell;
    logic [15:0] k_lo;
    logic [2:0]  cidx;
    logic [15:0] hx, hy, hz;
    fbm_lerp_t   lsel;
    logic [15:0] la, lb;
    logic [16:0] diff;
    logic [1:0]  aidx;
    logic [31:0] p32;
    logic [25:0] rr;

    fbm_mul u_mul
    (
        .a (mul_a),
        .b (mul_b),
        .p (prod)
    );

    assign fax      = cnt_reg[3:2];
    assign frac     = crd_reg[fax][15:0];
    assign six_f    = {3'd0, frac, 2'd0} + {4'd0, frac, 1'd0};
    assign hax      = cnt_reg[2:1];
    assign lat_cell = crd_reg[hax][31:16] + {15'd0, cnt_reg[0]};
    assign k_lo     = (hax == 2'd0) ? K_HX_LO : ((hax == 2'd1) ? K_HY_LO : K_HZ_LO);
    assign cidx     = cnt_reg[4:2];
    assign hx       = ah_reg[{2'b00, cidx[0]}];
    assign hy       = ah_reg[3'd2 + {2'b00, cidx[1]}];
    assign hz       = ah_reg[3'd4 + {2'b00, cidx[2]}];
    assign lsel     = lerp_sel(cnt_reg[2:0]);
    assign la       = crn_reg[lsel.la];
    assign lb       = crn_reg[lsel.lb];
    assign diff     = {1'b0, lb} - {1'b0, la};
    assign aidx     = cnt_reg[1:0];
    assign p32      = prod[47:16];

    // next state and step counter
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 5'd1;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (start)
                begin
                    state_next = (octave_count == 4'd0) ? ST_DONE : ST_FADE;
                end
            end
            ST_FADE:
            begin
                if (cnt_reg == LAST_FADE)
                begin
                    state_next = ST_AXHASH;
                    cnt_next   = '0;
                end
            end
            ST_AXHASH:
            begin
                if (cnt_reg == LAST_AXHASH)
                begin
                    state_next = ST_CORNER;
                    cnt_next   = '0;
                end
            end
            ST_CORNER:
            begin
                if (cnt_reg == LAST_CORNER)
                begin
                    state_next = ST_LERP;
                    cnt_next   = '0;
                end
            end
            ST_LERP:
            begin
                if (cnt_reg == LAST_LERP)
                begin
                    state_next = ST_ACC;
                    cnt_next   = '0;
                end
            end
            ST_ACC:
            begin
                if (cnt_reg == LAST_ACC)
                begin
                    state_next = ST_ADV;
                    cnt_next   = '0;
                end
            end
            ST_ADV:
            begin
                if (cnt_reg == LAST_ADV)
                begin
                    state_next = (oct_reg == 4'd1) ? ST_DONE : ST_FADE;
                    cnt_next   = '0;
                end
            end
            ST_DONE:
            begin
                cnt_next = '0;
                if (result_taken)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    // operand select and write back
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        oct_next  = oct_reg;
        amp_next  = amp_reg;
        acc_next  = acc_reg;
        f3_next   = f3_reg;
        t_next    = t_reg;
        d_next    = d_reg;
        crd_next  = crd_reg;
        fade_next = fade_reg;
        ah_next   = ah_reg;
        crn_next  = crn_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    crd_next[0] = {{8{x_coord[23]}}, x_coord};
                    crd_next[1] = {{8{y_coord[23]}}, y_coord};
                    crd_next[2] = {{8{z_coord[23]}}, z_coord};
                    oct_next    = (octave_count > 4'(MAX_OCTAVES)) ?
                                  4'(MAX_OCTAVES) : octave_count;
                    amp_next    = AMP_START;
                    acc_next    = '0;
                end
            end
            ST_FADE:
            begin
                case (cnt_reg[1:0])
                    2'd0:
                    begin
                        mul_a   = {17'd0, frac};
                        mul_b   = {10'd0, frac};
                        f3_next = prod[31:16];
                    end
                    2'd1:
                    begin
                        mul_a   = {17'd0, f3_reg};
                        mul_b   = {10'd0, frac};
                        f3_next = prod[31:16];
                    end
                    2'd2:
                    begin
                        // 6f - 15 is negative, the product floors toward minus infinity
                        mul_a  = {17'd0, frac};
                        mul_b  = {5'd0, six_f} - FIFTEEN_ONE;
                        t_next = prod[35:16] + TEN_ONE;
                    end
                    default:
                    begin
                        mul_a          = {17'd0, f3_reg};
                        mul_b          = {6'd0, t_reg};
                        fade_next[fax] = prod[32:16];
                    end
                endcase
            end
            ST_AXHASH:
            begin
                mul_a                = {17'd0, lat_cell};
                mul_b                = {10'd0, k_lo};
                ah_next[cnt_reg[2:0]] = prod[15:0];
            end
            ST_CORNER:
            begin
                case (cnt_reg[1:0])
                    2'd0:
                    begin
                        mul_a  = {17'd0, hx};
                        mul_b  = {5'd0, {5'd0, hy} + K_BIAS};
                        d_next = {2'd0, prod[36:16]};
                    end
                    2'd1:
                    begin
                        mul_a  = {17'd0, hy};
                        mul_b  = {5'd0, {5'd0, hz} + K_BIAS};
                        d_next = d_reg + {2'd0, prod[36:16]};
                    end
                    2'd2:
                    begin
                        mul_a  = {17'd0, hz};
                        mul_b  = {5'd0, {5'd0, hx} + K_BIAS};
                        d_next = d_reg + {2'd0, prod[36:16]};
                    end
                    default:
                    begin
                        mul_a          = {8'd0, {9'd0, hx} + {9'd0, hy} + {1'b0, d_reg, 1'b0}};
                        mul_b          = {2'd0, {8'd0, hz} + {1'b0, d_reg}};
                        crn_next[cidx] = prod[31:16];
                    end
                endcase
            end
            ST_LERP:
            begin
                mul_a             = {{16{diff[16]}}, diff};
                mul_b             = {9'd0, fade_reg[lsel.ax]};
                crn_next[lsel.la] = la + prod[31:16];
            end
            ST_ACC:
            begin
                if (cnt_reg[0] == 1'b0)
                begin
                    mul_a    = {17'd0, crn_reg[0]};
                    mul_b    = {10'd0, amp_reg};
                    acc_next = acc_reg + {1'b0, prod[31:16]};
                end
                else
                begin
                    mul_a    = {17'd0, amp_reg};
                    mul_b    = {10'd0, K_DECAY};
                    amp_next = prod[31:16];
                end
            end
            ST_ADV:
            begin
                mul_a = {crd_reg[aidx][31], crd_reg[aidx]};
                mul_b = {8'd0, K_SCALE};
                case (aidx)
                    2'd0:    crd_next[0] = p32 + K_OFFX;
                    2'd1:    crd_next[1] = p32 - K_OFFY;
                    default: crd_next[2] = p32 + K_OFFZ;
                endcase
                if (cnt_reg == LAST_ADV)
                begin
                    oct_next = oct_reg - 4'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            oct_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            oct_reg   <= oct_next;
        end
    end

    always_ff @(posedge clk)
    begin
        amp_reg  <= amp_next;
        acc_reg  <= acc_next;
        f3_reg   <= f3_next;
        t_reg    <= t_next;
        d_reg    <= d_next;
        crd_reg  <= crd_next;
        fade_reg <= fade_next;
        ah_reg   <= ah_next;
        crn_reg  <= crn_next;
    end

    // round(v*255), v is never negative here
    assign rr          = {1'b0, acc_reg, 8'd0} - {9'd0, acc_reg} + HALF;
    assign noise_value = (rr[25:16] > 10'd255) ? 8'hFF : rr[23:16];

    assign status.idle = (state_reg == ST_IDLE);
    assign status.done = (state_reg == ST_DONE);

`ifndef ASSERT_OFF
    a_fade_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FADE) |-> (cnt_reg <= LAST_FADE))
        else $error("fade step counter out of range");

    a_oct_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FADE || state_reg == ST_ADV) |-> (oct_reg != 4'd0))
        else $error("octave work with no octaves left");

    a_start_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && start && octave_count != 4'd0) |=> (state_reg == ST_FADE))
        else $error("accepted point did not start an octave");

    a_amp_falls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC && cnt_reg == LAST_ACC) |=> (amp_reg < $past(amp_reg)
            || $past(amp_reg) == 16'd0))
        else $error("amplitude did not decay");
`endif

endmodule

### src/fbm_value_noise_3d.sv
// Fractal value noise over a 3D point, one byte out per point.
// Input beat on s_axis: point x, y, z in signed Q8.16 and an octave count.
// Counts above 8 run 8 octaves; a count of zero returns 0.
// Output beat on m_axis: the noise byte, round(sum*255) clamped to 0..255.
// One point at a time: s_axis_tready is high only while the sequencer idles.
// All multiplications run through a single shared multiplier, one product
// per cycle while a point is in work. Each octave steps through fade, axis
// hash, corner hash, blend, sum/decay and point advance. The next point can
// be accepted in the cycle after the result is loaded into the output
// register.
// The output register holds one result; while the receiver stalls, the next
// point is still accepted and computed, and the block then waits with that
// second result until the register frees up.
// Reset clears the sequencer and the output valid; no state carries between
// points.
module fbm_value_noise_3d
    import fbm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // x_coord[23:0], y_coord[47:24], z_coord[71:48],
                                        // octave_count[75:72], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // noise_value[7:0]
);

    fbm_status_t status;
    logic        start;
    logic        load;
    logic [7:0]  result;
    logic        out_valid_reg;
    logic [7:0]  out_data_reg;

    assign s_axis_tready = status.idle;
    assign start         = s_axis_tvalid && status.idle;
    assign load          = status.done && (!out_valid_reg || m_axis_tready);

    fbm_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .x_coord      (s_axis_tdata[23:0]),
        .y_coord      (s_axis_tdata[47:24]),
        .z_coord      (s_axis_tdata[71:48]),
        .octave_count (s_axis_tdata[75:72]),
        .result_taken (load),
        .status       (status),
        .noise_value  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("pending result overwritten");

    a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !s_axis_tready)
        else $error("input taken while a point is in work");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result loaded into a full output register");
`endif

endmodule
